>>> rtl/core/sps_pkg.sv
// Package with shared constants of the segmented prime sieve.
package sps_pkg;
  localparam int LimitBitsDef = 20;
  localparam int BaseDepthDef = 256;
  localparam int SegDepthDef = 1024;
  localparam logic [19:0] LimitReset = 20'd100;
endpackage

>>> rtl/core/sps_cell.sv
// One sieve cell: holds a running multiple of its prime and marks a candidate.
module sps_cell
  import sps_pkg::*;
#(
  parameter int W = 21
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         set_prime,
  input  logic [W-1:0] prime_in,
  input  logic [W-1:0] cand,
  input  logic         step,
  input  logic         comp_in,
  output logic         comp_out,
  output logic         used
);
  logic [W-1:0] p;
  logic [W-1:0] mult;
  logic         hit;

  // The multiple only ever trails the candidate by less than one prime.
  always_comb begin
    hit = used && (mult == cand) && (cand != p);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (set_prime) begin
      used <= 1'b1;
      p <= prime_in;
      mult <= prime_in;
    end else if (step && used && mult < cand) begin
      mult <= mult + p;
    end
  end

  assign comp_out = comp_in | hit;
endmodule

>>> rtl/core/segmented_prime_sieve_unit.sv
// Top level of the segmented prime sieve: a row of cells, one per base prime.
//   channel | direction | data
//   s_axis  | in        | tdata[0] restart
//   m_axis  | out       | tdata[19:0] prime, tuser exhausted
//   cfg     | in        | data[19:0] upper_limit
// Each candidate number is tested in a catch-up step and a test step: the cells catch
// their multiples up, then the row reports whether any divides it. Requests are taken
// only while idle. A restart first finds the square root of the limit, then scans from 2.
// While an item waits on the output, the row holds in its catch-up cycle.
// Synchronous reset clears control; the output register frees the input side.
module segmented_prime_sieve_unit
  import sps_pkg::*;
#(
  parameter int LIMIT_BITS = LimitBitsDef,
  parameter int BASE_PRIME_DEPTH = BaseDepthDef,
  parameter int SEGMENT_DEPTH = SegDepthDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // restart
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [((LIMIT_BITS+7)/8)*8-1:0] m_axis_tdata, // prime
  output logic                  m_axis_tuser,   // exhausted
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [((LIMIT_BITS+7)/8)*8-1:0] cfg_data // upper_limit
);
  localparam int W = LIMIT_BITS + 1;
  localparam int OW = ((LIMIT_BITS + 7) / 8) * 8;
  localparam int CW = $clog2(BASE_PRIME_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_STEP = 4'b0010, S_TEST = 4'b0100, S_OUT = 4'b1000
  } state_t;

  state_t state;
  logic [LIMIT_BITS-1:0] limit_reg;
  logic [W-1:0] active, cand, seg_len;
  logic [CW-1:0] count;
  logic live;
  logic step, comp;
  logic [BASE_PRIME_DEPTH:0] chain;
  logic [BASE_PRIME_DEPTH-1:0] used_v;
  logic full;
  logic [W-1:0] lim_ext, sq;
  logic [W-1:0] root;
  logic [5:0] rbit;
  logic rooting;
  logic out_free;
  logic emit;
  logic emit_exh;
  logic [LIMIT_BITS-1:0] emit_prime;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign full = (count == CW'(BASE_PRIME_DEPTH));
  assign step = (state == S_STEP);
  assign chain[0] = 1'b0;
  assign comp = chain[BASE_PRIME_DEPTH];
  assign out_free = !m_axis_tvalid || m_axis_tready;

  genvar g;
  for (g = 0; g < BASE_PRIME_DEPTH; g++) begin : g_cells
    sps_cell #(.W(W)) u_cell (
      .clk(clk), .rst(rst || (s_axis_tvalid && s_axis_tready && s_axis_tdata[0])),
      .set_prime(state == S_TEST && !comp && !full && cand < seg_len
                 && count == CW'(g)),
      .prime_in(cand), .cand(cand), .step(step),
      .comp_in(chain[g]), .comp_out(chain[g+1]), .used(used_v[g])
    );
  end

  // Clamp limit against the mark store square; trial bit of the square root.
  always_comb begin
    lim_ext = W'(limit_reg);
    if (64'(limit_reg) > 64'(SEGMENT_DEPTH) * 64'(SEGMENT_DEPTH) - 64'd1)
      lim_ext = W'(64'(SEGMENT_DEPTH) * 64'(SEGMENT_DEPTH) - 64'd1);
    sq = root | (W'(1) << (rbit - 6'd1));
  end

  // An item leaves the row only when the output register is free.
  always_comb begin
    emit = 1'b0;
    emit_exh = 1'b1;
    emit_prime = '0;
    case (state)
      S_OUT: begin
        if (!rooting && out_free) emit = 1'b1;
      end
      S_STEP: begin
        if (cand > active && out_free) emit = 1'b1;
      end
      S_TEST: begin
        if (!comp) begin
          emit = 1'b1;
          emit_exh = 1'b0;
          emit_prime = cand[LIMIT_BITS-1:0];
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= LIMIT_BITS'(LimitReset);
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      live <= 1'b0;
      count <= '0;
      rooting <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) limit_reg <= cfg_data[LIMIT_BITS-1:0];
      if (emit) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= OW'(emit_prime);
        m_axis_tuser <= emit_exh;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            if (s_axis_tdata[0]) begin
              active <= lim_ext; root <= '0; rbit <= 6'(W / 2 + 1);
              rooting <= 1'b1; count <= '0; live <= 1'b1; cand <= W'(2);
              state <= S_OUT;
            end else begin
              state <= live ? S_STEP : S_OUT;
            end
          end
        end
        S_OUT: begin
          // Square root, one bit per cycle, after a restart.
          if (rooting) begin
            if (rbit == 0) begin
              rooting <= 1'b0;
              seg_len <= root + W'(1);
              state <= S_STEP;
            end else begin
              if ((2*W)'(sq) * (2*W)'(sq) <= (2*W)'(active)) root <= sq;
              rbit <= rbit - 6'd1;
            end
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_STEP: begin
          if (out_free) state <= (cand > active) ? S_IDLE : S_TEST;
        end
        S_TEST: begin
          cand <= cand + W'(1);
          if (!comp) begin
            if (cand < seg_len && full) begin
              seg_len <= cand;
              if (active > W'((2*W)'(cand) * (2*W)'(cand) - 1))
                active <= W'((2*W)'(cand) * (2*W)'(cand) - 1);
            end
            if (cand < seg_len && !full) count <= count + CW'(1);
            state <= S_IDLE;
          end else state <= S_STEP;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata != '0)
    else $error("prime zero without exhausted");
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == S_IDLE)
    else $error("accepting while busy");
  assert property (@(posedge clk) disable iff (rst)
    $countones(used_v) <= BASE_PRIME_DEPTH)
    else $error("cell count overflow");
  assert property (@(posedge clk) disable iff (rst)
    state == S_TEST |-> !m_axis_tvalid)
    else $error("test cycle with the output occupied");
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output item changed while waiting");
endmodule
